// File: design/erm_pkg.sv
// Shared types and constants for the roll-pitch-yaw to rotation matrix block.
// Holds item structs, CORDIC lane type and the arctangent table.
// No dependencies.
package erm_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int WORK_FRAC    = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} erm_in_t;

	typedef struct packed {
		logic signed [15:0] r00;
		logic signed [15:0] r01;
		logic signed [15:0] r02;
		logic signed [15:0] r10;
		logic signed [15:0] r11;
		logic signed [15:0] r12;
		logic signed [15:0] r20;
		logic signed [15:0] r21;
		logic signed [15:0] r22;
	} erm_out_t;

	// One angle in flight through the CORDIC chain (Q30 x/y, 2^32 per turn z)
	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [32:0] z;
		logic               flip;
	} erm_lane_t;

	// Lanes: 0 roll, 1 pitch, 2 yaw
	typedef erm_lane_t [2:0] erm_cell_t;

	// Sine and cosine of the three angles after the chain
	typedef struct packed {
		logic signed [33:0] sr;
		logic signed [33:0] cr;
		logic signed [33:0] sp;
		logic signed [33:0] cp;
		logic signed [33:0] sy;
		logic signed [33:0] cy;
	} erm_trig_t;

	function automatic logic signed [32:0] atan_turns(input int i);
		logic signed [32:0] a;
		case (i)
			0:  a = 33'sh020000000;
			1:  a = 33'sh012E4051E;
			2:  a = 33'sh009FB385B;
			3:  a = 33'sh0051111D4;
			4:  a = 33'sh0028B0D43;
			5:  a = 33'sh00145D7E1;
			6:  a = 33'sh000A2F61E;
			7:  a = 33'sh000517C55;
			8:  a = 33'sh00028BE53;
			9:  a = 33'sh000145F2F;
			10: a = 33'sh0000A2F98;
			11: a = 33'sh0000517CC;
			12: a = 33'sh000028BE6;
			13: a = 33'sh0000145F3;
			14: a = 33'sh00000A2FA;
			15: a = 33'sh00000517D;
			16: a = 33'sh0000028BE;
			17: a = 33'sh00000145F;
			18: a = 33'sh000000A30;
			19: a = 33'sh000000518;
			20: a = 33'sh00000028C;
			21: a = 33'sh000000146;
			22: a = 33'sh0000000A3;
			23: a = 33'sh000000051;
			24: a = 33'sh000000029;
			25: a = 33'sh000000014;
			26: a = 33'sh00000000A;
			27: a = 33'sh000000005;
			28: a = 33'sh000000003;
			29: a = 33'sh000000001;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

// File: design/erm_cordic_cell.sv
// One CORDIC rotation step for three angle lanes, with its own stage register.
// Depends on erm_pkg.
module erm_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  erm_pkg::erm_cell_t in_cell,
	output logic              out_valid,
	input  logic              out_ready,
	output erm_pkg::erm_cell_t out_cell
);
	import erm_pkg::*;

	localparam logic signed [32:0] ATAN = atan_turns(STEP);

	logic      valid_q;
	erm_cell_t cell_q;
	erm_cell_t nxt;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_cell  = cell_q;

	// rotate each lane toward z = 0
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			nxt[l].flip = in_cell[l].flip;
			if (!in_cell[l].z[32]) begin
				nxt[l].x = in_cell[l].x - (in_cell[l].y >>> STEP);
				nxt[l].y = in_cell[l].y + (in_cell[l].x >>> STEP);
				nxt[l].z = in_cell[l].z - ATAN;
			end else begin
				nxt[l].x = in_cell[l].x + (in_cell[l].y >>> STEP);
				nxt[l].y = in_cell[l].y - (in_cell[l].x >>> STEP);
				nxt[l].z = in_cell[l].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cell_q <= nxt;
		end
	end

endmodule

// File: design/erm_compose.sv
// Products of sines and cosines into the nine matrix entries, five stages.
// Depends on erm_pkg.
module erm_compose #(
	parameter int VALUE_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  erm_pkg::erm_cell_t in_cell,
	output logic              out_valid,
	input  logic              out_ready,
	output erm_pkg::erm_out_t out_data
);
	import erm_pkg::*;

	localparam int OSH = WORK_FRAC - VALUE_FRAC_BITS;
	localparam logic signed [35:0] HALF = (OSH > 0) ? (36'sd1 <<< ((OSH > 0) ? OSH - 1 : 0))
	                                               : 36'sd0;
	localparam logic signed [35:0] ONE  = 36'sd1 <<< VALUE_FRAC_BITS;
	localparam logic signed [67:0] RND  = 68'sd1 <<< (WORK_FRAC - 1);

	function automatic logic signed [33:0] rnd30(input logic signed [67:0] p);
		logic signed [67:0] t;
		t = (p + RND) >>> WORK_FRAC;
		return t[33:0];
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [35:0] v);
		logic signed [35:0] t;
		t = (v + HALF) >>> OSH;
		if (t > ONE) t = ONE;
		if (t < -ONE) t = -ONE;
		return t[15:0];
	endfunction

	// stage valids and ready chain
	logic [4:0] v_q;
	logic [4:0] rdy;
	assign rdy[4]    = !v_q[4] || out_ready;
	assign rdy[3]    = !v_q[3] || rdy[4];
	assign rdy[2]    = !v_q[2] || rdy[3];
	assign rdy[1]    = !v_q[1] || rdy[2];
	assign rdy[0]    = !v_q[0] || rdy[1];
	assign in_ready  = rdy[0];
	assign out_valid = v_q[4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) v_q[0] <= in_valid;
			if (rdy[1]) v_q[1] <= v_q[0];
			if (rdy[2]) v_q[2] <= v_q[1];
			if (rdy[3]) v_q[3] <= v_q[2];
			if (rdy[4]) v_q[4] <= v_q[3];
		end
	end

	// s1: undo the half-turn move
	erm_trig_t t_s1;
	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			t_s1.sr <= in_cell[0].flip ? -in_cell[0].y : in_cell[0].y;
			t_s1.cr <= in_cell[0].flip ? -in_cell[0].x : in_cell[0].x;
			t_s1.sp <= in_cell[1].flip ? -in_cell[1].y : in_cell[1].y;
			t_s1.cp <= in_cell[1].flip ? -in_cell[1].x : in_cell[1].x;
			t_s1.sy <= in_cell[2].flip ? -in_cell[2].y : in_cell[2].y;
			t_s1.cy <= in_cell[2].flip ? -in_cell[2].x : in_cell[2].x;
		end
	end

	// s2: first products, raw
	logic signed [67:0] cycp_s2, cysp_s2, sysp_s2, sycp_s2, cpsr_s2;
	logic signed [67:0] cpcr_s2, sycr_s2, sysr_s2, cycr_s2, cysr_s2;
	logic signed [33:0] sr_s2, cr_s2, sp_s2;
	always_ff @(posedge clk) begin
		if (v_q[0] && rdy[1]) begin
			cycp_s2 <= 68'(t_s1.cy) * 68'(t_s1.cp);
			cysp_s2 <= 68'(t_s1.cy) * 68'(t_s1.sp);
			sysp_s2 <= 68'(t_s1.sy) * 68'(t_s1.sp);
			sycp_s2 <= 68'(t_s1.sy) * 68'(t_s1.cp);
			cpsr_s2 <= 68'(t_s1.cp) * 68'(t_s1.sr);
			cpcr_s2 <= 68'(t_s1.cp) * 68'(t_s1.cr);
			sycr_s2 <= 68'(t_s1.sy) * 68'(t_s1.cr);
			sysr_s2 <= 68'(t_s1.sy) * 68'(t_s1.sr);
			cycr_s2 <= 68'(t_s1.cy) * 68'(t_s1.cr);
			cysr_s2 <= 68'(t_s1.cy) * 68'(t_s1.sr);
			sr_s2   <= t_s1.sr;
			cr_s2   <= t_s1.cr;
			sp_s2   <= t_s1.sp;
		end
	end

	// s3: round products back to Q30
	logic signed [33:0] cycp_s3, cysp_s3, sysp_s3, sycp_s3, cpsr_s3;
	logic signed [33:0] cpcr_s3, sycr_s3, sysr_s3, cycr_s3, cysr_s3;
	logic signed [33:0] sr_s3, cr_s3, sp_s3;
	always_ff @(posedge clk) begin
		if (v_q[1] && rdy[2]) begin
			cycp_s3 <= rnd30(cycp_s2);
			cysp_s3 <= rnd30(cysp_s2);
			sysp_s3 <= rnd30(sysp_s2);
			sycp_s3 <= rnd30(sycp_s2);
			cpsr_s3 <= rnd30(cpsr_s2);
			cpcr_s3 <= rnd30(cpcr_s2);
			sycr_s3 <= rnd30(sycr_s2);
			sysr_s3 <= rnd30(sysr_s2);
			cycr_s3 <= rnd30(cycr_s2);
			cysr_s3 <= rnd30(cysr_s2);
			sr_s3   <= sr_s2;
			cr_s3   <= cr_s2;
			sp_s3   <= sp_s2;
		end
	end

	// s4: three-factor products, raw
	logic signed [67:0] a01_s4, a02_s4, a11_s4, a12_s4;
	logic signed [33:0] cycp_s4, sycp_s4, cpsr_s4, cpcr_s4;
	logic signed [33:0] sycr_s4, sysr_s4, cycr_s4, cysr_s4, sp_s4;
	always_ff @(posedge clk) begin
		if (v_q[2] && rdy[3]) begin
			a01_s4  <= 68'(cysp_s3) * 68'(sr_s3);
			a02_s4  <= 68'(cysp_s3) * 68'(cr_s3);
			a11_s4  <= 68'(sysp_s3) * 68'(sr_s3);
			a12_s4  <= 68'(sysp_s3) * 68'(cr_s3);
			cycp_s4 <= cycp_s3;
			sycp_s4 <= sycp_s3;
			cpsr_s4 <= cpsr_s3;
			cpcr_s4 <= cpcr_s3;
			sycr_s4 <= sycr_s3;
			sysr_s4 <= sysr_s3;
			cycr_s4 <= cycr_s3;
			cysr_s4 <= cysr_s3;
			sp_s4   <= sp_s3;
		end
	end

	// s5: sums, output rounding and saturation
	erm_out_t res_s5;
	always_ff @(posedge clk) begin
		if (v_q[3] && rdy[4]) begin
			res_s5.r00 <= to_out(36'(cycp_s4));
			res_s5.r01 <= to_out(36'(rnd30(a01_s4)) - 36'(sycr_s4));
			res_s5.r02 <= to_out(36'(rnd30(a02_s4)) + 36'(sysr_s4));
			res_s5.r10 <= to_out(36'(sycp_s4));
			res_s5.r11 <= to_out(36'(rnd30(a11_s4)) + 36'(cycr_s4));
			res_s5.r12 <= to_out(36'(rnd30(a12_s4)) - 36'(cysr_s4));
			res_s5.r20 <= to_out(-36'(sp_s4));
			res_s5.r21 <= to_out(36'(cpsr_s4));
			res_s5.r22 <= to_out(36'(cpcr_s4));
		end
	end
	assign out_data = res_s5;

	// a stalled stage 3 keeps its item
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[2] && !rdy[3] |=> v_q[2] && $stable(sp_s3))
		else $error("stage 3 lost a stalled item");

	// an item leaving s1 lands in s2
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] && rdy[1] |=> v_q[1])
		else $error("stage 2 missed an item");

	// pitch sine and cosine stay within unit range plus CORDIC error
	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] |-> (t_s1.sp <= 34'sd1073800000) && (t_s1.sp >= -34'sd1073800000)
		        && (t_s1.cp <= 34'sd1073800000) && (t_s1.cp >= -34'sd1073800000))
		else $error("trig value out of range");

endmodule

// File: design/euler_rpy_to_rotation_matrix.sv
// Top level: roll-pitch-yaw angles to the ZYX rotation matrix in Q1.VALUE_FRAC_BITS.
// Depends on erm_pkg, erm_cordic_cell, erm_compose.
//
//  channel | signals                      | payload
//  in      | in_valid / in_ready          | in_data  (roll, pitch, yaw angles)
//  out     | out_valid / out_ready        | out_data (r00 .. r22)
//
// Pipeline: 30 CORDIC cells, one per rotation step, then five product stages.
// One item per cycle unless stalled; each registered stage takes an item every cycle.
// Reset clears only the stage valid bits.
// A stall at out_ready backs up stage by stage; empty stages keep filling meanwhile.
module euler_rpy_to_rotation_matrix #(
	parameter int ANGLE_BITS      = 16,
	parameter int VALUE_FRAC_BITS = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  erm_pkg::erm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output erm_pkg::erm_out_t out_data
);
	import erm_pkg::*;

	localparam logic [31:0] AMASK = (ANGLE_BITS >= 32) ? 32'hFFFF_FFFF
	                                                   : 32'((64'd1 << ANGLE_BITS) - 64'd1);
	localparam int ASH = 32 - ANGLE_BITS;

	function automatic erm_lane_t prep(input logic [15:0] ang);
		erm_lane_t   l;
		logic [31:0] p;
		logic [31:0] q;
		p = ({16'h0, ang} & AMASK) << ASH;
		q = p + 32'h4000_0000;
		l.flip = q[31];
		if (q[31]) p = p - 32'h8000_0000;
		l.z = {p[31], p};
		l.x = CORDIC_GAIN;
		l.y = '0;
		return l;
	endfunction

	// phase setup for each lane feeds the first cell
	erm_cell_t   chain [CORDIC_STEPS+1];
	logic        vld   [CORDIC_STEPS+1];
	logic        rdy   [CORDIC_STEPS+1];

	assign chain[0][0] = prep(in_data.roll_angle);
	assign chain[0][1] = prep(in_data.pitch_angle);
	assign chain[0][2] = prep(in_data.yaw_angle);
	assign vld[0]      = in_valid;
	assign in_ready    = rdy[0];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		erm_cordic_cell #(.STEP(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[i]),
			.in_ready (rdy[i]),
			.in_cell  (chain[i]),
			.out_valid(vld[i+1]),
			.out_ready(rdy[i+1]),
			.out_cell (chain[i+1])
		);
	end

	erm_compose #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_compose (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld[CORDIC_STEPS]),
		.in_ready (rdy[CORDIC_STEPS]),
		.in_cell  (chain[CORDIC_STEPS]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
